/* rtl/core/rsec_pkg.sv */
// ----------------------------------------------------------------------------
// rsec_pkg
// Shared types, opcodes, address map and controller/datapath interface types
// for the RV32I-subset execute core.
// ----------------------------------------------------------------------------
package rsec_pkg;

  // Storage sizes
  localparam int unsigned MEM_WORDS_DEFAULT = 512;
  localparam int unsigned REG_COUNT         = 32;
  localparam int unsigned REG_AW            = 5;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned IDX_W       = 6;

  // Opcodes
  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_HALF = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Address map
  localparam logic [31:0] ADDR_DATA_BASE = 32'h0000_0400;
  localparam logic [31:0] ADDR_IO_BASE   = 32'h0000_0800;
  localparam logic [31:0] ADDR_PUT_CHAR  = 32'h0000_0800;
  localparam logic [31:0] ADDR_PUT_INT   = 32'h0000_0804;
  localparam logic [31:0] ADDR_PUT_HEX   = 32'h0000_0808;
  localparam logic [31:0] ADDR_HALT      = 32'h0000_080C;
  localparam logic [31:0] ADDR_GET_CHAR  = 32'h0000_0812;
  localparam logic [31:0] ADDR_GET_INT   = 32'h0000_0816;
  localparam logic [31:0] ADDR_PUT_PC    = 32'h0000_0820;
  localparam logic [31:0] ADDR_DUMP      = 32'h0000_0824;
  localparam logic [31:0] ADDR_PUT_HEX2  = 32'h0000_0828;

  // Result kinds
  typedef enum logic [3:0] {
    KIND_RETIRED = 4'd0,
    KIND_CHAR    = 4'd1,
    KIND_INT     = 4'd2,
    KIND_HEX     = 4'd3,
    KIND_HALT    = 4'd4,
    KIND_PC      = 4'd5,
    KIND_DUMP    = 4'd6,
    KIND_UNKNOWN = 4'd7,
    KIND_ILLEGAL = 4'd8,
    KIND_STOPPED = 4'd9
  } kind_e;

  // Address regions
  typedef enum logic [1:0] {
    RGN_INSN    = 2'd0,
    RGN_DATA    = 2'd1,
    RGN_CONSOLE = 2'd2,
    RGN_ILLEGAL = 2'd3
  } region_e;

  // Result value sources
  typedef enum logic [2:0] {
    SRC_ZERO = 3'd0,
    SRC_PC   = 3'd1,
    SRC_INSN = 3'd2,
    SRC_EV   = 3'd3,
    SRC_NEXT = 3'd4,
    SRC_REG  = 3'd5
  } src_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM, ST_WB,
    ST_ERR, ST_BADPC, ST_STOP, ST_HALT, ST_EVT,
    ST_DUMP_PC, ST_DUMP_RD, ST_DUMP_EM, ST_RETIRE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic  in_ready;
    logic  accept;
    logic  load_wr;
    logic  clear_step;
    logic  fetch;
    logic  decode;
    logic  exec;
    logic  mem_rd;
    logic  wb;
    logic  dump_start;
    logic  dump_rd;
    logic  emit;
    kind_e emit_kind;
    src_e  emit_src;
    logic  emit_last;
    logic  commit;
    logic  set_stop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  clear_done;
    logic  in_valid;
    logic  in_step;
    logic  stopped;
    logic  bad_pc;
    logic  failed;
    kind_e err_kind;
    logic  halt;
    logic  ev_valid;
    kind_e ev_kind;
    logic  dump_req;
    logic  out_free;
    logic  dump_last;
  } sts_t;

  // Map an effective address to its region
  function automatic region_e classify(input logic [31:0] a);
    region_e r;
    if (a < ADDR_DATA_BASE) r = RGN_INSN;
    else if (a < ADDR_IO_BASE) r = RGN_DATA;
    else if (a == ADDR_PUT_CHAR || a == ADDR_PUT_INT || a == ADDR_PUT_HEX ||
             a == ADDR_HALT || a == ADDR_GET_CHAR || a == ADDR_GET_INT ||
             a == ADDR_PUT_PC || a == ADDR_DUMP || a == ADDR_PUT_HEX2) r = RGN_CONSOLE;
    else r = RGN_ILLEGAL;
    return r;
  endfunction

endpackage

/* rtl/core/rsec_regfile.sv */
// ----------------------------------------------------------------------------
// rsec_regfile
// 32 x 32 register file, one write port and two registered read ports.
// Per-entry valid bits make every register read as zero after reset.
// ----------------------------------------------------------------------------
module rsec_regfile (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [rsec_pkg::REG_AW-1:0] waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic                       a_re_i,
  input  logic [rsec_pkg::REG_AW-1:0] a_addr_i,
  output logic [31:0]                a_data_o,
  input  logic                       b_re_i,
  input  logic [rsec_pkg::REG_AW-1:0] b_addr_i,
  output logic [31:0]                b_data_o
);

  logic [31:0]                    regs_q [rsec_pkg::REG_COUNT];
  logic [rsec_pkg::REG_COUNT-1:0] valid_q;
  logic [31:0]                    a_data_q, b_data_q;

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs_q[waddr_i] <= wdata_i;
    end
    if (a_re_i) begin
      a_data_q <= valid_q[a_addr_i] ? regs_q[a_addr_i] : 32'd0;
    end
    if (b_re_i) begin
      b_data_q <= valid_q[b_addr_i] ? regs_q[b_addr_i] : 32'd0;
    end
  end

  assign a_data_o = a_data_q;
  assign b_data_o = b_data_q;

endmodule

/* rtl/core/rsec_dpath.sv */
// ----------------------------------------------------------------------------
// rsec_dpath
// Datapath: main memory, register file, decode and ALU, load/store unit,
// console event capture and the result output register.
// ----------------------------------------------------------------------------
module rsec_dpath #(
  parameter int unsigned MEM_WORDS = rsec_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rsec_pkg::cmd_t                     cmd_i,
  output rsec_pkg::sts_t                     sts_o,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rsec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rsec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [3:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

  // Input fields
  logic [8:0]  in_index;
  logic [31:0] in_data, in_cin;
  assign in_index = s_axis_tdata[8:0];
  assign in_data  = s_axis_tdata[40:9];
  assign in_cin   = s_axis_tdata[72:41];

  // Architectural and pipeline registers
  logic [31:0]             pc_q, cin_q, insn_q, mrd_q;
  logic [31:0]             wval_q, next_q, addr_q, sval_q, ev_val_q;
  logic                    stop_q, is_load_q, is_store_q, wr_q;
  logic                    ev_valid_q, halt_q, dump_q;
  rsec_pkg::kind_e         err_q, ev_kind_q;
  rsec_pkg::region_e       region_q;
  logic [MEM_AW-1:0]       clr_cnt_q;
  logic [rsec_pkg::IDX_W-1:0] dump_cnt_q;

  // Output register
  logic                    out_valid_q, out_last_q;
  logic [31:0]             out_value_q;
  logic [rsec_pkg::IDX_W-1:0] out_idx_q;
  rsec_pkg::kind_e         out_kind_q;

  // Register file
  logic [31:0] rs1v, rs2v;
  logic        rf_we, rf_a_re;
  logic [rsec_pkg::REG_AW-1:0] rf_a_addr;
  logic [rsec_pkg::IDX_W-1:0]  dump_rd_idx;

  assign dump_rd_idx = dump_cnt_q - rsec_pkg::IDX_W'(1);
  assign rf_a_re     = cmd_i.decode | cmd_i.dump_rd;
  assign rf_a_addr   = cmd_i.decode ? mrd_q[19:15] : dump_rd_idx[rsec_pkg::REG_AW-1:0];
  assign rf_we       = cmd_i.commit & wr_q & (insn_q[11:7] != '0);

  rsec_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (rf_we),
    .waddr_i  (insn_q[11:7]),
    .wdata_i  (wval_q),
    .a_re_i   (rf_a_re),
    .a_addr_i (rf_a_addr),
    .a_data_o (rs1v),
    .b_re_i   (cmd_i.decode),
    .b_addr_i (mrd_q[24:20]),
    .b_data_o (rs2v)
  );

  // ---------------------------------------------------------------- execute
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, opb, alu, ea, sv;
  logic [4:0]  shamt;
  logic        lt_s, lt_u, take;
  rsec_pkg::region_e e_region;
  rsec_pkg::kind_e   e_err, e_ev_kind;
  logic        e_wr, e_load, e_store, e_ev, e_halt, e_dump;
  logic [31:0] e_wval, e_next, e_ev_val;

  assign op    = insn_q[6:0];
  assign f3    = insn_q[14:12];
  assign f7    = insn_q[31:25];
  assign imm_i = {{20{insn_q[31]}}, insn_q[31:20]};
  assign imm_s = {{20{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};
  assign imm_b = {{19{insn_q[31]}}, insn_q[31], insn_q[7], insn_q[30:25],
                  insn_q[11:8], 1'b0};
  assign imm_j = {{11{insn_q[31]}}, insn_q[31], insn_q[19:12], insn_q[20],
                  insn_q[30:21], 1'b0};
  // Register and branch forms compare rs2, immediate forms the I immediate
  assign opb   = (op == rsec_pkg::OP_R || op == rsec_pkg::OP_BRANCH) ? rs2v : imm_i;
  assign shamt = rs2v[4:0];
  assign lt_s  = $signed(rs1v) < $signed(opb);
  assign lt_u  = rs1v < rs2v;
  assign ea    = rs1v + ((op == rsec_pkg::OP_STORE) ? imm_s : imm_i);
  assign e_region = rsec_pkg::classify(ea);

  // Shared ALU for register and immediate forms
  always_comb begin
    case (f3)
      rsec_pkg::F3_ADD: alu = (op == rsec_pkg::OP_R && f7 == rsec_pkg::F7_ALT) ?
                              rs1v - opb : rs1v + opb;
      rsec_pkg::F3_SLL: alu = rs1v << shamt;
      rsec_pkg::F3_SLT: alu = {31'd0, lt_s};
      rsec_pkg::F3_XOR: alu = rs1v ^ opb;
      rsec_pkg::F3_SR:  alu = (f7 == rsec_pkg::F7_ALT) ?
                              32'($signed(rs1v) >>> shamt) : rs1v >> shamt;
      rsec_pkg::F3_OR:  alu = rs1v | opb;
      default:          alu = rs1v & opb;
    endcase
  end

  // Branch condition
  always_comb begin
    case (f3)
      rsec_pkg::F3_BEQ:  take = rs1v == rs2v;
      rsec_pkg::F3_BNE:  take = rs1v != rs2v;
      rsec_pkg::F3_BLT:  take = lt_s;
      rsec_pkg::F3_BGE:  take = ~lt_s;
      rsec_pkg::F3_BLTU: take = lt_u;
      default:           take = ~lt_u;
    endcase
  end

  // Store value masked to its width
  always_comb begin
    case (f3)
      rsec_pkg::F3_BYTE: sv = {24'd0, rs2v[7:0]};
      rsec_pkg::F3_HALF: sv = {16'd0, rs2v[15:0]};
      default:           sv = rs2v;
    endcase
  end

  // Decode, legality and console event capture
  always_comb begin
    e_err     = rsec_pkg::KIND_RETIRED;
    e_wr      = 1'b0;
    e_load    = 1'b0;
    e_store   = 1'b0;
    e_ev      = 1'b0;
    e_ev_kind = rsec_pkg::KIND_CHAR;
    e_ev_val  = sv;
    e_halt    = 1'b0;
    e_dump    = 1'b0;
    e_wval    = alu;
    e_next    = pc_q + 32'd4;
    unique case (op)
      rsec_pkg::OP_R: begin
        e_wr = 1'b1;
        if (!((f7 == rsec_pkg::F7_BASE && f3 != 3'd3) ||
              (f7 == rsec_pkg::F7_ALT && (f3 == rsec_pkg::F3_ADD ||
                                           f3 == rsec_pkg::F3_SR)))) begin
          e_err = rsec_pkg::KIND_UNKNOWN;
        end
      end
      rsec_pkg::OP_IMM: begin
        e_wr = 1'b1;
        if (f3 == rsec_pkg::F3_SLL || f3 == rsec_pkg::F3_SR || f3 == 3'd3) begin
          e_err = rsec_pkg::KIND_UNKNOWN;
        end
      end
      rsec_pkg::OP_JALR: begin
        e_wr   = 1'b1;
        e_wval = pc_q + 32'd4;
        e_next = (rs1v + imm_i) & ~32'd1;
        if (f3 != rsec_pkg::F3_ADD) e_err = rsec_pkg::KIND_UNKNOWN;
      end
      rsec_pkg::OP_LOAD: begin
        e_wr   = 1'b1;
        e_load = 1'b1;
        if (f3 != rsec_pkg::F3_WORD && f3 != rsec_pkg::F3_BU) begin
          e_err = rsec_pkg::KIND_UNKNOWN;
        end else if (e_region == rsec_pkg::RGN_ILLEGAL) begin
          e_err = rsec_pkg::KIND_ILLEGAL;
        end
      end
      rsec_pkg::OP_STORE: begin
        e_store = 1'b1;
        if (f3 != rsec_pkg::F3_BYTE && f3 != rsec_pkg::F3_HALF &&
            f3 != rsec_pkg::F3_WORD) begin
          e_err = rsec_pkg::KIND_UNKNOWN;
        end else if (e_region == rsec_pkg::RGN_ILLEGAL) begin
          e_err = rsec_pkg::KIND_ILLEGAL;
        end else if (e_region == rsec_pkg::RGN_CONSOLE) begin
          if (ea == rsec_pkg::ADDR_PUT_CHAR) begin
            e_ev = 1'b1;
            e_ev_kind = rsec_pkg::KIND_CHAR;
            e_ev_val  = {24'd0, sv[7:0]};
          end else if (ea == rsec_pkg::ADDR_PUT_INT) begin
            e_ev = 1'b1;
            e_ev_kind = rsec_pkg::KIND_INT;
          end else if (ea == rsec_pkg::ADDR_PUT_HEX || ea == rsec_pkg::ADDR_PUT_HEX2) begin
            e_ev = 1'b1;
            e_ev_kind = rsec_pkg::KIND_HEX;
          end else if (ea == rsec_pkg::ADDR_PUT_PC) begin
            e_ev = 1'b1;
            e_ev_kind = rsec_pkg::KIND_PC;
            e_ev_val  = pc_q;
          end else if (ea == rsec_pkg::ADDR_DUMP) begin
            e_dump = 1'b1;
          end else if (ea == rsec_pkg::ADDR_HALT) begin
            e_halt = 1'b1;
          end
        end
      end
      rsec_pkg::OP_BRANCH: begin
        if (f3 == 3'd2 || f3 == 3'd3) e_err = rsec_pkg::KIND_UNKNOWN;
        else if (take) e_next = pc_q + imm_b;
      end
      rsec_pkg::OP_LUI: begin
        e_wr   = 1'b1;
        e_wval = {insn_q[31:12], 12'd0};
      end
      rsec_pkg::OP_JAL: begin
        e_wr   = 1'b1;
        e_wval = pc_q + 32'd4;
        e_next = pc_q + imm_j;
      end
      default: begin
        e_err = rsec_pkg::KIND_UNKNOWN;
      end
    endcase
  end

  // ------------------------------------------------------------- load/store
  logic [31:0] io_word, ld_val, st_mask, st_merge;
  logic [4:0]  st_sh;
  logic        st_wr;

  always_comb begin
    if (addr_q == rsec_pkg::ADDR_GET_CHAR) io_word = {24'd0, cin_q[7:0]};
    else if (addr_q == rsec_pkg::ADDR_GET_INT) io_word = cin_q;
    else io_word = 32'd0;
    if (region_q == rsec_pkg::RGN_CONSOLE) begin
      ld_val = (insn_q[14:12] == rsec_pkg::F3_WORD) ? io_word : {24'd0, io_word[7:0]};
    end else if (insn_q[14:12] == rsec_pkg::F3_WORD) begin
      ld_val = mrd_q;
    end else begin
      ld_val = {24'd0, 8'(mrd_q >> {addr_q[1:0], 3'd0})};
    end
    case (insn_q[14:12])
      rsec_pkg::F3_BYTE: begin
        st_mask = 32'h0000_00FF;
        st_sh   = {addr_q[1:0], 3'd0};
      end
      rsec_pkg::F3_HALF: begin
        st_mask = 32'h0000_FFFF;
        st_sh   = {addr_q[1], 4'd0};
      end
      default: begin
        st_mask = 32'hFFFF_FFFF;
        st_sh   = 5'd0;
      end
    endcase
    st_merge = (mrd_q & ~(st_mask << st_sh)) | (sval_q << st_sh);
  end

  assign st_wr = cmd_i.wb & is_store_q & (region_q == rsec_pkg::RGN_DATA) &
                 (err_q == rsec_pkg::KIND_RETIRED);

  // ----------------------------------------------------------------- memory
  logic [31:0]       mem_q [MEM_WORDS];
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  // Pick the write port owner: clearing pass, program load, then store
  always_comb begin
    mem_we    = cmd_i.clear_step | cmd_i.load_wr | st_wr;
    mem_waddr = MEM_AW'(addr_q[10:2]);
    mem_wdata = st_merge;
    if (cmd_i.clear_step) begin
      mem_waddr = clr_cnt_q;
      mem_wdata = 32'd0;
    end else if (cmd_i.load_wr) begin
      mem_waddr = MEM_AW'(in_index);
      mem_wdata = in_data;
    end
  end

  assign mem_re    = cmd_i.fetch | cmd_i.mem_rd;
  assign mem_raddr = cmd_i.fetch ? MEM_AW'(pc_q[9:2]) : MEM_AW'(addr_q[10:2]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mrd_q <= mem_q[mem_raddr];
    end
  end

  // ----------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      stop_q      <= 1'b0;
      clr_cnt_q   <= '0;
      dump_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
      if (cmd_i.commit) pc_q <= next_q;
      if (cmd_i.set_stop) stop_q <= 1'b1;
      if (cmd_i.dump_start) dump_cnt_q <= rsec_pkg::IDX_W'(1);
      else if (cmd_i.emit && cmd_i.emit_src == rsec_pkg::SRC_REG) begin
        dump_cnt_q <= dump_cnt_q + rsec_pkg::IDX_W'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // ----------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cin_q <= in_cin;
    if (cmd_i.decode) insn_q <= mrd_q;
    if (cmd_i.exec) begin
      err_q      <= e_err;
      wr_q       <= e_wr;
      is_load_q  <= e_load;
      is_store_q <= e_store;
      ev_valid_q <= e_ev;
      ev_kind_q  <= e_ev_kind;
      ev_val_q   <= e_ev_val;
      halt_q     <= e_halt;
      dump_q     <= e_dump;
      wval_q     <= e_wval;
      next_q     <= e_next;
      addr_q     <= ea;
      sval_q     <= sv;
      region_q   <= e_region;
    end
    if (cmd_i.wb && is_load_q) wval_q <= ld_val;
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_last_q <= cmd_i.emit_last;
      out_idx_q  <= (cmd_i.emit_src == rsec_pkg::SRC_REG) ? dump_cnt_q : '0;
      case (cmd_i.emit_src)
        rsec_pkg::SRC_PC:   out_value_q <= pc_q;
        rsec_pkg::SRC_INSN: out_value_q <= insn_q;
        rsec_pkg::SRC_EV:   out_value_q <= ev_val_q;
        rsec_pkg::SRC_NEXT: out_value_q <= next_q;
        rsec_pkg::SRC_REG:  out_value_q <= rs1v;
        default:            out_value_q <= 32'd0;
      endcase
    end
  end

  // ----------------------------------------------------------------- status
  always_comb begin
    sts_o.clear_done = (clr_cnt_q == MEM_AW'(MEM_WORDS - 1));
    sts_o.in_valid   = s_axis_tvalid;
    sts_o.in_step    = s_axis_tuser;
    sts_o.stopped    = stop_q;
    sts_o.bad_pc     = (pc_q[1:0] != 2'd0) || (pc_q >= rsec_pkg::ADDR_DATA_BASE);
    sts_o.failed     = (err_q != rsec_pkg::KIND_RETIRED);
    sts_o.err_kind   = err_q;
    sts_o.halt       = halt_q;
    sts_o.ev_valid   = ev_valid_q;
    sts_o.ev_kind    = ev_kind_q;
    sts_o.dump_req   = dump_q;
    sts_o.out_free   = ~out_valid_q | m_axis_tready;
    sts_o.dump_last  = (dump_cnt_q == rsec_pkg::IDX_W'(rsec_pkg::REG_COUNT));
  end

  assign s_axis_tready = cmd_i.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, out_idx_q, out_value_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/rsec_ctrl.sv */
// ----------------------------------------------------------------------------
// rsec_ctrl
// Sequencer for the execute core: memory clearing pass, fetch, decode,
// execute, memory access, write-back and result emission with dumps.
// ----------------------------------------------------------------------------
module rsec_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rsec_pkg::sts_t sts_i,
  output rsec_pkg::cmd_t cmd_o
);

  rsec_pkg::state_e state_q, state_d;
  logic             fail_q, fail_d;
  logic             accept;

  assign accept = (state_q == rsec_pkg::ST_IDLE) & sts_i.in_valid;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsec_pkg::ST_CLEAR;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    unique case (state_q)
      rsec_pkg::ST_CLEAR: begin
        if (sts_i.clear_done) state_d = rsec_pkg::ST_IDLE;
      end
      rsec_pkg::ST_IDLE: begin
        if (accept && sts_i.in_step) begin
          fail_d = 1'b0;
          if (sts_i.stopped) state_d = rsec_pkg::ST_STOP;
          else if (sts_i.bad_pc) state_d = rsec_pkg::ST_BADPC;
          else state_d = rsec_pkg::ST_FETCH;
        end
      end
      rsec_pkg::ST_FETCH:  state_d = rsec_pkg::ST_DECODE;
      rsec_pkg::ST_DECODE: state_d = rsec_pkg::ST_EXEC;
      rsec_pkg::ST_EXEC:   state_d = rsec_pkg::ST_MEM;
      rsec_pkg::ST_MEM:    state_d = rsec_pkg::ST_WB;
      rsec_pkg::ST_WB: begin
        if (sts_i.failed) state_d = rsec_pkg::ST_ERR;
        else if (sts_i.halt) state_d = rsec_pkg::ST_HALT;
        else if (sts_i.ev_valid) state_d = rsec_pkg::ST_EVT;
        else if (sts_i.dump_req) state_d = rsec_pkg::ST_DUMP_PC;
        else state_d = rsec_pkg::ST_RETIRE;
      end
      rsec_pkg::ST_ERR, rsec_pkg::ST_BADPC: begin
        if (sts_i.out_free) begin
          fail_d  = 1'b1;
          state_d = rsec_pkg::ST_DUMP_PC;
        end
      end
      rsec_pkg::ST_EVT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.dump_req ? rsec_pkg::ST_DUMP_PC : rsec_pkg::ST_RETIRE;
        end
      end
      rsec_pkg::ST_DUMP_PC: begin
        if (sts_i.out_free) state_d = rsec_pkg::ST_DUMP_RD;
      end
      rsec_pkg::ST_DUMP_RD: state_d = rsec_pkg::ST_DUMP_EM;
      rsec_pkg::ST_DUMP_EM: begin
        if (sts_i.out_free) begin
          if (!sts_i.dump_last) state_d = rsec_pkg::ST_DUMP_RD;
          else if (fail_q) state_d = rsec_pkg::ST_IDLE;
          else state_d = rsec_pkg::ST_RETIRE;
        end
      end
      rsec_pkg::ST_STOP, rsec_pkg::ST_HALT, rsec_pkg::ST_RETIRE: begin
        if (sts_i.out_free) state_d = rsec_pkg::ST_IDLE;
      end
      default: state_d = rsec_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.emit_kind  = rsec_pkg::KIND_RETIRED;
    cmd_o.emit_src   = rsec_pkg::SRC_ZERO;
    cmd_o.accept     = accept;
    cmd_o.load_wr    = accept & ~sts_i.in_step;
    unique case (state_q)
      rsec_pkg::ST_CLEAR:  cmd_o.clear_step = 1'b1;
      rsec_pkg::ST_IDLE:   cmd_o.in_ready   = 1'b1;
      rsec_pkg::ST_FETCH:  cmd_o.fetch      = 1'b1;
      rsec_pkg::ST_DECODE: cmd_o.decode     = 1'b1;
      rsec_pkg::ST_EXEC:   cmd_o.exec       = 1'b1;
      rsec_pkg::ST_MEM:    cmd_o.mem_rd     = 1'b1;
      rsec_pkg::ST_WB:     cmd_o.wb         = 1'b1;
      rsec_pkg::ST_ERR: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = sts_i.err_kind;
        cmd_o.emit_src  = rsec_pkg::SRC_INSN;
      end
      rsec_pkg::ST_BADPC: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = rsec_pkg::KIND_ILLEGAL;
      end
      rsec_pkg::ST_STOP: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = rsec_pkg::KIND_STOPPED;
        cmd_o.emit_src  = rsec_pkg::SRC_PC;
        cmd_o.emit_last = 1'b1;
      end
      rsec_pkg::ST_HALT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = rsec_pkg::KIND_HALT;
        cmd_o.emit_last = 1'b1;
        cmd_o.set_stop  = sts_i.out_free;
      end
      rsec_pkg::ST_EVT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = sts_i.ev_kind;
        cmd_o.emit_src  = rsec_pkg::SRC_EV;
      end
      rsec_pkg::ST_DUMP_PC: begin
        cmd_o.emit       = sts_i.out_free;
        cmd_o.emit_kind  = rsec_pkg::KIND_DUMP;
        cmd_o.emit_src   = rsec_pkg::SRC_PC;
        cmd_o.dump_start = sts_i.out_free;
      end
      rsec_pkg::ST_DUMP_RD: cmd_o.dump_rd = 1'b1;
      rsec_pkg::ST_DUMP_EM: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = rsec_pkg::KIND_DUMP;
        cmd_o.emit_src  = rsec_pkg::SRC_REG;
        cmd_o.emit_last = sts_i.dump_last & fail_q;
        cmd_o.set_stop  = sts_i.out_free & sts_i.dump_last & fail_q;
      end
      rsec_pkg::ST_RETIRE: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = rsec_pkg::KIND_RETIRED;
        cmd_o.emit_src  = rsec_pkg::SRC_NEXT;
        cmd_o.emit_last = 1'b1;
        cmd_o.commit    = sts_i.out_free;
      end
      default: cmd_o.in_ready = 1'b0;
    endcase
  end

endmodule

/* rtl/core/rv32i_subset_execute_core.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_execute_core
// Multicycle RV32I-subset core driven by program-load and step transactions.
// ----------------------------------------------------------------------------
// After reset the core sweeps main memory to zero, one word per cycle, and
// takes no transaction until the sweep is done. A program-load transaction
// then writes one word and gives no result. A step transaction runs fetch,
// decode, execute, memory and write-back through the one read port of main
// memory and the registered register-file reads, then emits its results one
// per cycle while the output register is free; each register-dump entry is
// first read from the register file through one port. The next transaction
// is taken once the final result sits in the output register.
module rv32i_subset_execute_core #(
  parameter int unsigned MEM_WORDS = rsec_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [8:0] word_index, [40:9] word_data, [72:41] console_in
  input  logic [rsec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] action
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] value, [37:32] entry_index
  output logic [rsec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [3:0] kind
  output logic [3:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  rsec_pkg::cmd_t cmd;
  rsec_pkg::sts_t sts;

  rsec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rsec_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
